// ----- rtl/i2c_master_bit_sequencer_assert.svh -----
// ============================================================================
// i2c_master_bit_sequencer_assert.svh
// Assertion macros shared by the bit sequencer RTL; empty under synthesis.
// ============================================================================
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define I2CMS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define I2CMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2CMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define I2CMS_ASSERT(lbl, clk, rstn, prop, msg)
`define I2CMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define I2CMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/i2cms_pkg.sv -----
// ============================================================================
// i2cms_pkg
// Types, command codes and phase tables of the I2C master bit sequencer.
// ============================================================================
package i2cms_pkg;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_ACK   = 3'd4,
        OP_NACK  = 3'd5
    } op_t;

    localparam logic [2:0] OP_LAST = 3'd5;

    // Input word: one phase tick.
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] op;
        logic [7:0] write_byte;
        logic       sda_level;
    } in_word_t;

    // Output word: line levels and status of one phase tick.
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       cmd_accepted;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } out_word_t;

    // Classified tick, as queued between front and back.
    typedef struct packed {
        logic       cmd_ok;
        op_t        op;
        logic [7:0] load_byte;
        logic       sda_level;
    } cls_word_t;

    localparam int unsigned PH_W = 5;

    // Number of phases per command.
    function automatic logic [PH_W-1:0] phase_count(input op_t op);
        logic [PH_W-1:0] cnt;
        unique case (op)
            OP_START: cnt = 5'd5;
            OP_STOP:  cnt = 5'd4;
            OP_WRITE: cnt = 5'd25;
            OP_READ:  cnt = 5'd17;
            OP_ACK:   cnt = 5'd4;
            OP_NACK:  cnt = 5'd2;
            default:  cnt = 5'd2;
        endcase
        return cnt;
    endfunction

    // Phase modulo 3, exact for phases 0..23 (reciprocal 11/32).
    function automatic logic [1:0] phase_mod3(input logic [PH_W-1:0] ph);
        logic [8:0] prod;
        logic [2:0] quot;
        logic [4:0] rem;
        prod = {4'd0, ph} * 9'd11;
        quot = prod[7:5];
        rem  = ph - ({2'd0, quot} * 5'd3);
        return rem[1:0];
    endfunction

endpackage

// ----- rtl/i2cms_front.sv -----
// ============================================================================
// i2cms_front
// Takes input words and classifies them into queue entries.
// ============================================================================
module i2cms_front (
    input  logic                  item_valid,
    output logic                  item_ready,
    input  i2cms_pkg::in_word_t   item,
    input  logic                  full,
    output logic                  push,
    output i2cms_pkg::cls_word_t  push_word
);

    logic op_legal;

    assign op_legal   = (item.op <= i2cms_pkg::OP_LAST);
    assign item_ready = !full;
    assign push       = item_valid && !full;

    always_comb
    begin
        push_word.cmd_ok    = item.cmd_valid && op_legal;
        push_word.op        = op_legal ? i2cms_pkg::op_t'(item.op) : i2cms_pkg::OP_NACK;
        push_word.load_byte = (item.op == i2cms_pkg::OP_WRITE) ? item.write_byte : 8'd0;
        push_word.sda_level = item.sda_level;
    end

endmodule

// ----- rtl/i2cms_queue.sv -----
// ============================================================================
// i2cms_queue
// Small register FIFO between the front and back parts.
// ============================================================================
`include "i2c_master_bit_sequencer_assert.svh"

module i2cms_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  i2cms_pkg::cls_word_t  push_word,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output i2cms_pkg::cls_word_t  head_word
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    i2cms_pkg::cls_word_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_word  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    `I2CMS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_FULL, "queue count beyond depth")
    `I2CMS_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, head_valid, "pop from empty queue")
    `I2CMS_ASSERT_NXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "push did not grow queue")

endmodule

// ----- rtl/i2cms_back.sv -----
// ============================================================================
// i2cms_back
// Phase sequencer: runs one tick per queue entry into the output register.
// ============================================================================
`include "i2c_master_bit_sequencer_assert.svh"

module i2cms_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  i2cms_pkg::cls_word_t  head_word,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_ready,
    output i2cms_pkg::out_word_t  result
);

    localparam int unsigned PH_W = i2cms_pkg::PH_W;

    logic                 active_reg, active_next;
    i2cms_pkg::op_t       op_reg, op_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 result_valid_reg;
    i2cms_pkg::out_word_t result_reg, result_next;

    logic                 start;
    logic                 run;
    logic                 last;
    i2cms_pkg::op_t       cur_op;
    logic [PH_W-1:0]      ph;
    logic [7:0]           sh;
    logic [1:0]           sub;
    logic [PH_W:0]        ph_inc;

    assign pop          = head_valid && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        start  = !active_reg && head_word.cmd_ok;
        run    = active_reg || start;
        cur_op = start ? head_word.op : op_reg;
        ph     = start ? '0 : phase_reg;
        sh     = start ? head_word.load_byte : shift_reg;
        sub    = i2cms_pkg::phase_mod3(ph);
        ph_inc = {1'b0, ph} + 1'b1;
        last   = run && (ph_inc >= {1'b0, i2cms_pkg::phase_count(cur_op)});

        scl_next   = scl_reg;
        sda_next   = sda_reg;
        shift_next = sh;

        if (run)
        begin
            unique case (cur_op)
                i2cms_pkg::OP_START:
                begin
                    priority if (ph == 5'd0 || ph == 5'd4) scl_next = 1'b0;
                    else if (ph == 5'd1) sda_next = 1'b1;
                    else if (ph == 5'd2) scl_next = 1'b1;
                    else sda_next = 1'b0;
                end
                i2cms_pkg::OP_STOP:
                begin
                    priority if (ph == 5'd0) scl_next = 1'b0;
                    else if (ph == 5'd1) sda_next = 1'b0;
                    else if (ph == 5'd2) scl_next = 1'b1;
                    else sda_next = 1'b1;
                end
                i2cms_pkg::OP_WRITE:
                begin
                    // three phases per bit: set data, raise clock, drop clock
                    priority if (ph >= 5'd24) sda_next = 1'b1;
                    else if (sub == 2'd0) sda_next = sh[7];
                    else if (sub == 2'd1) scl_next = 1'b1;
                    else
                    begin
                        scl_next   = 1'b0;
                        shift_next = {sh[6:0], 1'b0};
                    end
                end
                i2cms_pkg::OP_READ:
                begin
                    // odd phases sample SDA while SCL is high
                    priority if (ph == 5'd0) sda_next = 1'b1;
                    else if (ph[0])
                    begin
                        scl_next   = 1'b1;
                        shift_next = {sh[6:0], head_word.sda_level};
                    end
                    else scl_next = 1'b0;
                end
                i2cms_pkg::OP_ACK:
                begin
                    priority if (ph == 5'd0) sda_next = 1'b0;
                    else if (ph == 5'd1) scl_next = 1'b1;
                    else if (ph == 5'd2) scl_next = 1'b0;
                    else sda_next = 1'b1;
                end
                default:
                begin
                    scl_next = (ph == 5'd0);
                end
            endcase
        end

        active_next = run && !last;
        op_next     = cur_op;
        phase_next  = (run && !last) ? ph_inc[PH_W-1:0] : '0;

        result_next.scl_release  = scl_next;
        result_next.sda_release  = sda_next;
        result_next.cmd_accepted = start;
        result_next.busy_res     = run;
        result_next.done_res     = last;
        result_next.read_byte    = (last && cur_op == i2cms_pkg::OP_READ) ? shift_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            op_reg           <= i2cms_pkg::OP_START;
            phase_reg        <= '0;
            shift_reg        <= '0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= active_next;
                op_reg     <= op_next;
                phase_reg  <= phase_next;
                shift_reg  <= shift_next;
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
            end
            if (pop)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    `I2CMS_ASSERT_IMP(a_done_busy, clk, rst_n, result_valid_reg && result_reg.done_res, result_reg.busy_res, "done without busy")
    `I2CMS_ASSERT_IMP(a_rbyte_done, clk, rst_n, result_valid_reg && !result_reg.done_res, result_reg.read_byte == 8'd0, "read byte outside done")
    `I2CMS_ASSERT_IMP(a_idle_phase, clk, rst_n, !active_reg, phase_reg == '0, "phase count not cleared when idle")

endmodule

// ----- rtl/i2c_master_bit_sequencer.sv -----
// ============================================================================
// i2c_master_bit_sequencer
// Open-drain I2C master line sequencer, one phase per input word.
// ============================================================================
// Each input word is one phase tick and yields exactly one output word with
// the SCL/SDA release levels for that tick plus status. The block sustains
// one word per clock while the queue is not full and the output is taken:
// the front classifies a word in the cycle it arrives, the word is
// registered in the queue (QUEUE_DEPTH entries), and the back runs the phase
// and loads the output register, so a result is valid only after its word
// has passed through the queue entry and the output register. Commands:
// start 5 phases, stop 4, write 25,
// read 17, ack 4, nack 2. A command word is latched only while idle and runs
// its first phase in the same tick; command words arriving while busy, and
// unknown op codes, are ignored (cmd_accepted stays 0). Writes go MSB first
// and release SDA at the end; reads sample SDA in each SCL-high phase, MSB
// first, and show the byte on the done tick. The slave ACK is not checked.
// ============================================================================
module i2c_master_bit_sequencer #(
    parameter int unsigned QUEUE_DEPTH = 2   // 2..16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  i2cms_pkg::in_word_t   item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output i2cms_pkg::out_word_t  result
);

    // front -> queue
    logic                 push;
    logic                 full;
    i2cms_pkg::cls_word_t push_word;

    // queue -> back
    logic                 head_valid;
    logic                 pop;
    i2cms_pkg::cls_word_t head_word;

    // Front: decode op legality and preload the write shift byte.
    i2cms_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .full       (full),
        .push       (push),
        .push_word  (push_word)
    );

    // Queue decouples input stalls from output stalls.
    i2cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    // Back: phase state machine and registered output word.
    i2cms_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_word    (head_word),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
